// File: rtl/eccc_pkg.sv
// shared types and constants for the elevator car controller
`timescale 1ns / 1ps
package eccc_pkg;
  localparam int FLOORS_DEF = 16;
  localparam int LIST_DEPTH = 16;
  localparam int LIST_AW = 4;
  localparam int CNT_W = 5;
  localparam int FLOOR_W = 4;
  localparam logic [15:0] DOOR_TICKS_RST = 16'd30;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_UP   = 2'd1,
    M_DOWN = 2'd2,
    M_DOOR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    H_NONE = 2'd0,
    H_UP   = 2'd1,
    H_DOWN = 2'd2
  } heading_t;

  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;

  // what to decide once the front entry has been read
  typedef enum logic [1:0] {
    P_NONE,
    P_START,
    P_ARRIVE,
    P_REPLAN
  } plan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_CHK,
    S_APPEND,
    S_SORT_LD,
    S_SORT_LD_CHK,
    S_SORT_RD,
    S_SORT_CHK,
    S_SORT_PUT,
    S_PURGE,
    S_PURGE_CHK,
    S_FRONT,
    S_FRONT_CHK,
    S_OUT
  } seq_t;
endpackage

// File: rtl/elevator_car_controller_core.sv
// elevator car controller top level: sequencer around a stop-list memory
//
//  channel   | signals                               | transfer when
//  ----------+---------------------------------------+-------------------
//  input     | in_valid in_ready command floor dir.  | in_valid & in_ready
//  result    | out_valid out_ready accepted ...      | out_valid & out_ready
//  config    | cfg_we cfg_data                       | cfg_we
//
// one item at a time; a plain step passes through decode, front read and output,
// the duplicate scan and the purge read each listed stop in turn, and an add
// with a full insertion sort of sixteen entries reads and shifts entry by entry,
// all set by the one read port of the stop-list memory
// synchronous reset clears control state; the list memory is not cleared
// a result waits in the output register; the next item is taken once it leaves
`timescale 1ns / 1ps
module elevator_car_controller_core
  import eccc_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [FLOOR_W-1:0]   floor,
  input  logic [1:0]           direction,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [FLOOR_W-1:0]   current_floor,
  output logic [1:0]           car_state,
  output logic [1:0]           travel_direction,
  output logic [FLOOR_W-1:0]   next_stop,
  output logic [CNT_W-1:0]     stop_count,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);
  localparam logic [FLOOR_W:0] TOP = (FLOOR_W+1)'(FLOORS - 1);

  // stop list memory, one write and one registered read port
  logic [FLOOR_W-1:0] mem [LIST_DEPTH];
  logic               we;
  logic [LIST_AW-1:0] waddr, raddr;
  logic [FLOOR_W-1:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  seq_t seq, seq_next;
  logic [15:0] door_ticks;
  logic [CNT_W-1:0] pcnt, pcnt_next;
  logic [FLOOR_W-1:0] car_floor, car_floor_next;
  mode_t mode, mode_next;
  heading_t heading, heading_next;
  logic [15:0] tim, tim_next;
  logic [CNT_W-1:0] idx, idx_next, k, k_next;
  logic [FLOOR_W-1:0] front, front_next;
  logic [FLOOR_W-1:0] sort_val, sort_val_next;
  plan_t plan, plan_next;
  logic ok, ok_next;
  logic cmd_r;
  logic [FLOOR_W-1:0] fl_r;
  logic [1:0] dir_r;
  logic [15:0] tim_inc;
  logic [FLOOR_W:0] nf;
  logic mv_up;

  // register file of the car
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      door_ticks <= DOOR_TICKS_RST;
      pcnt <= '0;
      car_floor <= '0;
      mode <= M_IDLE;
      heading <= H_NONE;
      tim <= '0;
      out_valid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (cfg_we) door_ticks <= cfg_data;
      pcnt <= pcnt_next;
      car_floor <= car_floor_next;
      mode <= mode_next;
      heading <= heading_next;
      tim <= tim_next;
      if (seq == S_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // item and scratch registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    k <= k_next;
    front <= front_next;
    sort_val <= sort_val_next;
    plan <= plan_next;
    ok <= ok_next;
    if (in_valid && in_ready) begin
      cmd_r <= command;
      fl_r <= floor;
      dir_r <= direction;
    end
    if (seq == S_OUT) begin
      accepted <= ok;
      current_floor <= car_floor;
      car_state <= mode;
      travel_direction <= heading;
      next_stop <= (pcnt != '0) ? front : '0;
      stop_count <= pcnt;
    end
  end

  assign in_ready = (seq == S_IDLE) && !(out_valid && !out_ready);
  assign tim_inc = (tim != 16'hFFFF) ? tim + 16'd1 : tim;
  assign mv_up = (mode == M_UP);
  assign nf = mv_up ? ((({1'b0, car_floor}) < TOP) ? {1'b0, car_floor} + 1'b1
                                                   : {1'b0, car_floor})
                    : ((car_floor != '0) ? {1'b0, car_floor} - 1'b1
                                         : {1'b0, car_floor});

  // sequencer: decode, scan, append, insertion sort, purge, front read, output
  always_comb begin
    seq_next = seq;
    pcnt_next = pcnt;
    car_floor_next = car_floor;
    mode_next = mode;
    heading_next = heading;
    tim_next = tim;
    idx_next = idx;
    k_next = k;
    front_next = front;
    sort_val_next = sort_val;
    plan_next = plan;
    ok_next = ok;
    we = 1'b0;
    waddr = k[LIST_AW-1:0];
    wdata = fl_r;
    raddr = idx[LIST_AW-1:0];
    case (seq)
      S_IDLE: begin
        if (in_valid && in_ready) seq_next = S_DECODE;
      end
      S_DECODE: begin
        ok_next = 1'b0;
        idx_next = '0;
        k_next = '0;
        plan_next = P_NONE;
        seq_next = S_FRONT;
        if (cmd_r) begin
          if (!({1'b0, fl_r} > TOP || pcnt >= CNT_W'(LIST_DEPTH))) seq_next = S_SCAN;
        end else begin
          // step one tick
          case (mode)
            M_IDLE: begin
              if (pcnt != '0) begin
                ok_next = 1'b1;
                plan_next = P_START;
              end
            end
            M_DOOR: begin
              tim_next = tim_inc;
              if (tim_inc >= door_ticks) seq_next = S_PURGE;
            end
            default: begin
              if (nf[FLOOR_W-1:0] != car_floor) begin
                ok_next = 1'b1;
                car_floor_next = nf[FLOOR_W-1:0];
                plan_next = P_ARRIVE;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx >= pcnt) seq_next = S_APPEND;
        else seq_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // a duplicate refuses the request
        if (rdata == fl_r) seq_next = S_FRONT;
        else begin
          idx_next = idx + 1'b1;
          seq_next = S_SCAN;
        end
      end
      S_APPEND: begin
        we = 1'b1;
        waddr = pcnt[LIST_AW-1:0];
        wdata = fl_r;
        pcnt_next = pcnt + 1'b1;
        ok_next = 1'b1;
        if (mode == M_IDLE) begin
          tim_next = '0;
          if (fl_r > car_floor) begin
            mode_next = M_UP; heading_next = H_UP;
          end else if (fl_r < car_floor) begin
            mode_next = M_DOWN; heading_next = H_DOWN;
          end else begin
            mode_next = M_DOOR;
            heading_next = (dir_r == DIR_UP) ? H_UP : H_DOWN;
          end
        end
        idx_next = CNT_W'(1);
        if ((dir_r == DIR_UP || dir_r == DIR_DOWN) && pcnt != '0) seq_next = S_SORT_LD;
        else seq_next = S_FRONT;
      end
      S_SORT_LD: begin
        if (idx >= pcnt) seq_next = S_FRONT;
        else seq_next = S_SORT_LD_CHK;
      end
      S_SORT_LD_CHK: begin
        sort_val_next = rdata;
        k_next = idx;
        seq_next = S_SORT_RD;
      end
      S_SORT_RD: begin
        raddr = k[LIST_AW-1:0] - 1'b1;
        if (k == '0) seq_next = S_SORT_PUT;
        else seq_next = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        // shift the entry below up one place while it is out of order
        if ((dir_r == DIR_DOWN) ? (rdata < sort_val) : (rdata > sort_val)) begin
          we = 1'b1;
          waddr = k[LIST_AW-1:0];
          wdata = rdata;
          k_next = k - 1'b1;
          seq_next = S_SORT_RD;
        end else seq_next = S_SORT_PUT;
      end
      S_SORT_PUT: begin
        we = 1'b1;
        waddr = k[LIST_AW-1:0];
        wdata = sort_val;
        idx_next = idx + 1'b1;
        seq_next = S_SORT_LD;
      end
      S_PURGE: begin
        if (idx >= pcnt) begin
          pcnt_next = k;
          ok_next = 1'b1;
          plan_next = P_REPLAN;
          seq_next = S_FRONT;
        end else seq_next = S_PURGE_CHK;
      end
      S_PURGE_CHK: begin
        // keep every stop except the served floor
        if (rdata != car_floor) begin
          we = 1'b1; waddr = k[LIST_AW-1:0]; wdata = rdata;
          k_next = k + 1'b1;
        end
        idx_next = idx + 1'b1;
        seq_next = S_PURGE;
      end
      S_FRONT: begin
        raddr = '0;
        seq_next = S_FRONT_CHK;
      end
      S_FRONT_CHK: begin
        front_next = rdata;
        case (plan)
          P_START: begin
            tim_next = '0;
            mode_next = (rdata > car_floor) ? M_UP : (rdata < car_floor) ? M_DOWN : M_DOOR;
          end
          P_ARRIVE: begin
            // moving car arrived one floor further
            if (pcnt != '0 && car_floor == rdata) begin
              mode_next = M_DOOR; tim_next = '0;
            end else if (({1'b0, car_floor} == TOP && mode == M_UP) ||
                         (car_floor == '0 && mode == M_DOWN)) begin
              tim_next = '0;
              if (pcnt == '0) mode_next = M_IDLE;
              else mode_next = (rdata > car_floor) ? M_UP : M_DOWN;
            end
          end
          P_REPLAN: begin
            tim_next = '0;
            if (pcnt == '0) mode_next = M_IDLE;
            else mode_next = (rdata > car_floor) ? M_UP : M_DOWN;
          end
          default: ;
        endcase
        seq_next = S_OUT;
      end
      S_OUT: seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  // the stop count never exceeds the list depth
  a_cnt: assert property (@(posedge clk) disable iff (rst) pcnt <= CNT_W'(LIST_DEPTH))
    else $error("stop count overflow");
  // no new item is taken while a result is in flight
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken during work");
  // a result is presented right after the output stage
  a_out: assert property (@(posedge clk) disable iff (rst) (seq == S_OUT) |=> out_valid)
    else $error("result lost");
endmodule
